[src/pnlst_pkg.sv]
// shared types and constants for the per-node location slot table
`default_nettype none
package pnlst_pkg;

  // command codes
  localparam logic CMD_RECEIVED = 1'b0;
  localparam logic CMD_OWN_FIX  = 1'b1;

  localparam int unsigned ID_W      = 4;
  localparam int unsigned STAMP_W   = 17;
  localparam int unsigned OWN_ID_RESET = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // input word as received
  typedef struct packed {
    logic        cmd;
    logic [3:0]  node_id;
    logic [4:0]  utc_hours;
    logic [5:0]  utc_minutes;
    logic [5:0]  utc_seconds;
    logic [31:0] latitude_word;
    logic [31:0] longitude_word;
    logic [7:0]  hops_in;
  } in_item_t;

  // result word
  typedef struct packed {
    logic       written;
    logic [1:0] slot_used;
    logic       took_empty;
  } res_item_t;

  // classified item between front and back
  typedef struct packed {
    logic                cmd;
    logic                in_range;
    logic [ID_W-1:0]     node;
    logic [STAMP_W-1:0]  stamp;
    logic [31:0]         lat;
    logic [31:0]         lon;
    logic [7:0]          hops;
  } cls_item_t;

  // one slot's decision fields
  typedef struct packed {
    logic [ID_W-1:0]    owner;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

  // queue handshake between modules
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

[src/pnlst_queue.sv]
// two-entry queue of classified items between front and back
`default_nettype none
module pnlst_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  wire pnlst_pkg::cls_item_t push_item,
  input  wire                    pop,
  output pnlst_pkg::cls_item_t   head,
  output pnlst_pkg::q_status_t   status
);
  import pnlst_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  cls_item_t          entry [QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        count;

  // status and head
  always_comb begin
    status.full  = (count == (PW+1)'(QUEUE_DEPTH));
    status.empty = (count == '0);
    head         = entry[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // never push into a full queue nor pop an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("queue popped while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

[src/pnlst_front.sv]
// front end: own id register, input accept and classification
`default_nettype none
module pnlst_front #(
  parameter int unsigned NODES = 16
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire pnlst_pkg::in_item_t in_data,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [3:0]               cfg_data,
  input  wire pnlst_pkg::q_status_t q_status,
  output logic                    push,
  output pnlst_pkg::cls_item_t    push_item
);
  import pnlst_pkg::*;

  logic [ID_W-1:0] own_node_id;
  logic [ID_W-1:0] eff_node;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id <= ID_W'(OWN_ID_RESET);
    end else if (cfg_valid) begin
      own_node_id <= cfg_data;
    end
  end

  // accept when the queue has room
  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  // classify: pick the node, check range, pack the time stamp
  always_comb begin
    eff_node = (in_data.cmd == CMD_OWN_FIX) ? own_node_id : in_data.node_id;
    push_item.cmd      = in_data.cmd;
    push_item.node     = eff_node;
    push_item.in_range = (32'(eff_node) < NODES);
    push_item.stamp    = {in_data.utc_hours, in_data.utc_minutes, in_data.utc_seconds};
    push_item.lat      = in_data.latitude_word;
    push_item.lon      = in_data.longitude_word;
    push_item.hops     = (in_data.cmd == CMD_OWN_FIX) ? 8'd0 : in_data.hops_in;
  end

endmodule
`default_nettype wire

[src/pnlst_back.sv]
// back end: row memory, slot scan, row update and result register
`default_nettype none
module pnlst_back #(
  parameter int unsigned NODES = 16,
  parameter int unsigned SLOTS = 4
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire pnlst_pkg::cls_item_t head,
  input  wire pnlst_pkg::q_status_t q_status,
  output logic                     pop,
  output logic                     out_valid,
  input  wire                      out_ready,
  output pnlst_pkg::res_item_t     out_data
);
  import pnlst_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } st_t;

  typedef slot_entry_t [SLOTS-1:0] row_t;

  st_t st;

  // row memory: decision fields and own ring pointer, one row per node
  row_t          row_mem [NODES];
  logic [SW-1:0] ptr_mem [NODES];
  logic [NODES-1:0] row_valid;
  // record payload memory, one entry per node and slot
  logic [71:0]   rec_mem [NODES << SW];

  row_t          rd_row;
  logic [SW-1:0] rd_ptr;
  logic          rd_hit;
  row_t          row_q;
  logic [SW-1:0] ptr_q;

  cls_item_t     cur;
  logic [NW-1:0] cur_row;
  logic [NW-1:0] head_row;

  // scan state
  logic [SW-1:0]      scan_k;
  logic               found;
  logic [SW-1:0]      first_free;
  logic [SW-1:0]      oldest;
  logic [STAMP_W-1:0] min_stamp;
  slot_entry_t        scan_ent;
  logic               scan_last;

  // decision
  logic          do_write;
  logic [SW-1:0] sel;
  logic          took_empty;
  logic [SW-1:0] ptr_adv;
  logic [SW:0]   ptr_inc;
  row_t          new_row;
  logic [SW-1:0] ptr_new;
  logic          out_free;
  logic          finish;
  logic [3:0]    sel_ext;

  assign head_row = NW'(head.node);
  assign cur_row  = NW'(cur.node);

  // a row never written reads as all zero
  assign row_q = rd_hit ? rd_row : '0;
  assign ptr_q = rd_hit ? rd_ptr : '0;

  assign pop      = (st == ST_IDLE) && !q_status.empty;
  assign out_free = !out_valid || out_ready;
  assign finish   = (st == ST_WRITE) && out_free;

  // row read, registered
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_row <= row_mem[head_row];
      rd_ptr <= ptr_mem[head_row];
      cur    <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (pop) begin
      rd_hit <= row_valid[head_row];
    end
  end

  // one slot per cycle: first empty and first oldest
  assign scan_ent  = row_q[scan_k];
  assign scan_last = (32'(scan_k) == SLOTS - 1);

  always_ff @(posedge clk) begin
    if (pop) begin
      scan_k <= '0;
      found  <= 1'b0;
    end else if (st == ST_SCAN) begin
      scan_k <= scan_k + 1'b1;
      if (!found && scan_ent.owner == '0) begin
        found      <= 1'b1;
        first_free <= scan_k;
      end
      if (scan_k == '0 || scan_ent.stamp < min_stamp) begin
        oldest    <= scan_k;
        min_stamp <= scan_ent.stamp;
      end
    end
  end

  // pick the slot and build the updated row
  always_comb begin
    ptr_inc = {1'b0, ptr_q} + 1'b1;
    ptr_adv = (32'(ptr_inc) >= SLOTS) ? '0 : ptr_inc[SW-1:0];
    do_write   = 1'b0;
    sel        = '0;
    took_empty = 1'b0;
    ptr_new    = ptr_q;
    if (cur.in_range) begin
      if (cur.cmd == CMD_OWN_FIX) begin
        sel        = ptr_q;
        do_write   = 1'b1;
        took_empty = (row_q[ptr_q].owner == '0);
        ptr_new    = ptr_adv;
      end else if (found) begin
        sel        = first_free;
        do_write   = 1'b1;
        took_empty = 1'b1;
      end else begin
        sel      = oldest;
        do_write = (cur.stamp > min_stamp);
      end
    end
    new_row = row_q;
    new_row[sel].owner = cur.node;
    new_row[sel].stamp = cur.stamp;
    sel_ext = 4'(sel);
  end

  // row and payload write-back
  always_ff @(posedge clk) begin
    if (finish && do_write) begin
      row_mem[cur_row] <= new_row;
      ptr_mem[cur_row] <= ptr_new;
      rec_mem[{cur_row, sel}] <= {cur.lat, cur.lon, cur.hops};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (finish && do_write) begin
      row_valid[cur_row] <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      case (st)
        ST_IDLE: begin
          if (pop) begin
            st <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            st <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data.written    <= do_write;
      out_data.slot_used  <= sel_ext[1:0];
      out_data.took_empty <= took_empty;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    st == ST_SCAN |-> 32'(scan_k) < SLOTS)
    else $error("slot scan ran past the last slot");
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    st == ST_WRITE |-> 32'(ptr_q) < SLOTS)
    else $error("own ring pointer out of range");
  a_empty_means_written: assert property (@(posedge clk) disable iff (rst)
    (finish && took_empty) |-> do_write)
    else $error("empty slot taken without a write");
  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == ST_WRITE))
    else $error("result appeared outside the write step");

endmodule
`default_nettype wire

[src/per_node_location_slot_table.sv]
// top level of the per-node location slot table
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    in_item_t
//   out      output     out_valid / out_ready  res_item_t
//   cfg      input      cfg_valid / cfg_ready  own node id, 4 bits
//
// in the back end each word goes through a row read, a scan of its slots
// in order and a write-back, which waits while a result is still held; a new
// word is popped only when the last is done; the row read is registered as
// the word leaves the queue; per-row valid flags make unwritten rows read as empty
// the front keeps accepting while the queue has room; a result waiting in
// the output register holds only the back end
`default_nettype none
module per_node_location_slot_table #(
  parameter int unsigned NODES = 16,
  parameter int unsigned SLOTS = 4
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire pnlst_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output pnlst_pkg::res_item_t      out_data,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire [3:0]                 cfg_data
);
  import pnlst_pkg::*;

  logic      push;
  logic      pop;
  cls_item_t push_item;
  cls_item_t head;
  q_status_t q_status;

  // accept and classify
  pnlst_front #(
    .NODES(NODES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  pnlst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // table update
  pnlst_back #(
    .NODES(NODES),
    .SLOTS(SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
